@@ design/lap_stopwatch_defines.svh @@
// Assertion macros used by the stopwatch core.
`ifndef LAP_STOPWATCH_DEFINES_SVH
`define LAP_STOPWATCH_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define LSW_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lsw_pkg.sv @@
// Types and constants of the lap stopwatch.
package lsw_pkg;

    // Event codes carried by an input item
    typedef enum logic [2:0] {
        MODE_TICK         = 3'd0,
        MODE_START        = 3'd1,
        MODE_PAUSE        = 3'd2,
        MODE_TOGGLE       = 3'd3,
        MODE_RESET        = 3'd4,
        MODE_LAP          = 3'd5,
        MODE_LAP_OR_RESET = 3'd6,
        MODE_READ_LAP     = 3'd7
    } t_mode;

    // Reported watch state
    typedef enum logic [1:0] {
        WATCH_RESET   = 2'd0,
        WATCH_RUNNING = 2'd1,
        WATCH_PAUSED  = 2'd2
    } t_watch_state;

    // Digit limits of the mixed-radix time counters
    localparam logic [3:0] MS_DIGIT_MAX = 4'd9;
    localparam logic [6:0] CENTI_MAX    = 7'd99;
    localparam logic [5:0] SEC_MAX      = 6'd59;
    localparam logic [6:0] MIN_MAX      = 7'd99;

    // Formatted time: minutes, seconds, centiseconds
    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [6:0] centis;
    } t_time;

    // One result item
    typedef struct packed {
        t_time        elapsed;
        t_watch_state watch_state;
        logic [7:0]   laps_stored;
        logic         lap_found;
        t_time        lap;
    } t_result;

endpackage

@@ design/lsw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lsw_ram #(
    parameter int WIDTH  = 20,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/lsw_core.sv @@
// Stopwatch state: run flag, elapsed count with formatted digits, lap counter.
`include "lap_stopwatch_defines.svh"

module lsw_core #(
    parameter int MAX_LAPS = 16,
    parameter int ADDR_W   = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  lsw_pkg::t_mode     i_mode,
    input  logic [7:0]         i_lap_index,
    input  lsw_pkg::t_time     i_lap_data,
    output lsw_pkg::t_result   o_result,
    output logic               o_lap_wr_en,
    output logic [ADDR_W-1:0]  o_lap_wr_addr,
    output lsw_pkg::t_time     o_lap_wr_data
);
    import lsw_pkg::*;

    localparam logic [7:0] LAP_LIMIT = 8'(MAX_LAPS);

    logic        r_run,      n_run;
    logic [31:0] r_elapsed,  n_elapsed;
    logic [3:0]  r_ms_digit, n_ms_digit;
    logic [6:0]  r_centis,   n_centis;
    logic [5:0]  r_seconds,  n_seconds;
    logic [6:0]  r_minutes,  n_minutes;
    logic [7:0]  r_lap_cnt,  n_lap_cnt;
    logic        lap_take;
    logic        lap_found;

    // Event decode and next state
    always_comb begin
        n_run      = r_run;
        n_elapsed  = r_elapsed;
        n_ms_digit = r_ms_digit;
        n_centis   = r_centis;
        n_seconds  = r_seconds;
        n_minutes  = r_minutes;
        n_lap_cnt  = r_lap_cnt;
        lap_take   = 1'b0;
        unique case (i_mode)
            MODE_TICK: begin
                if (r_run) begin
                    if (&r_elapsed) begin
                        // count wraps to zero, so every digit does too
                        n_elapsed  = '0;
                        n_ms_digit = '0;
                        n_centis   = '0;
                        n_seconds  = '0;
                        n_minutes  = '0;
                    end else begin
                        n_elapsed = r_elapsed + 32'd1;
                        if (r_ms_digit == MS_DIGIT_MAX) begin
                            n_ms_digit = '0;
                            if (r_centis == CENTI_MAX) begin
                                n_centis = '0;
                                if (r_seconds == SEC_MAX) begin
                                    n_seconds = '0;
                                    if (r_minutes != MIN_MAX) begin
                                        n_minutes = r_minutes + 7'd1;
                                    end
                                end else begin
                                    n_seconds = r_seconds + 6'd1;
                                end
                            end else begin
                                n_centis = r_centis + 7'd1;
                            end
                        end else begin
                            n_ms_digit = r_ms_digit + 4'd1;
                        end
                    end
                end
            end
            MODE_START:  n_run = 1'b1;
            MODE_PAUSE:  n_run = 1'b0;
            MODE_TOGGLE: n_run = !r_run;
            MODE_RESET: begin
                n_run      = 1'b0;
                n_elapsed  = '0;
                n_ms_digit = '0;
                n_centis   = '0;
                n_seconds  = '0;
                n_minutes  = '0;
                n_lap_cnt  = '0;
            end
            MODE_LAP: begin
                lap_take = r_run && (r_lap_cnt < LAP_LIMIT);
            end
            MODE_LAP_OR_RESET: begin
                if (r_run) begin
                    lap_take = r_lap_cnt < LAP_LIMIT;
                end else begin
                    n_elapsed  = '0;
                    n_ms_digit = '0;
                    n_centis   = '0;
                    n_seconds  = '0;
                    n_minutes  = '0;
                    n_lap_cnt  = '0;
                end
            end
            MODE_READ_LAP: begin
            end
        endcase
        if (lap_take) begin
            n_lap_cnt = r_lap_cnt + 8'd1;
        end
    end

    // State registers, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b0;
            r_elapsed  <= '0;
            r_ms_digit <= '0;
            r_centis   <= '0;
            r_seconds  <= '0;
            r_minutes  <= '0;
            r_lap_cnt  <= '0;
        end else if (i_en) begin
            r_run      <= n_run;
            r_elapsed  <= n_elapsed;
            r_ms_digit <= n_ms_digit;
            r_centis   <= n_centis;
            r_seconds  <= n_seconds;
            r_minutes  <= n_minutes;
            r_lap_cnt  <= n_lap_cnt;
        end
    end

    // Lap store write: current time goes into the next free entry
    assign o_lap_wr_en           = i_en && lap_take;
    assign o_lap_wr_addr         = r_lap_cnt[ADDR_W-1:0];
    assign o_lap_wr_data.minutes = r_minutes;
    assign o_lap_wr_data.seconds = r_seconds;
    assign o_lap_wr_data.centis  = r_centis;

    // Result from the state after the event; a read leaves the counter alone
    assign lap_found = (i_mode == MODE_READ_LAP) && (i_lap_index < r_lap_cnt);

    always_comb begin
        o_result.elapsed.minutes = n_minutes;
        o_result.elapsed.seconds = n_seconds;
        o_result.elapsed.centis  = n_centis;
        if (n_run) begin
            o_result.watch_state = WATCH_RUNNING;
        end else if ((n_elapsed != '0) || (n_lap_cnt != '0)) begin
            o_result.watch_state = WATCH_PAUSED;
        end else begin
            o_result.watch_state = WATCH_RESET;
        end
        o_result.laps_stored = n_lap_cnt;
        o_result.lap_found   = lap_found;
        o_result.lap         = lap_found ? i_lap_data : '0;
    end

    `LSW_ASSERT_ALWAYS(a_lap_cnt_bound, i_clk, i_rst_n, r_lap_cnt <= LAP_LIMIT,
        "lap counter beyond store depth")
    `LSW_ASSERT_ALWAYS(a_digit_range, i_clk, i_rst_n,
        (r_ms_digit <= MS_DIGIT_MAX) && (r_centis <= CENTI_MAX) &&
        (r_seconds <= SEC_MAX) && (r_minutes <= MIN_MAX), "time digit out of range")
    `LSW_ASSERT_IMP(a_zero_digits, i_clk, i_rst_n, r_elapsed == '0,
        (r_ms_digit == '0) && (r_centis == '0) && (r_seconds == '0) && (r_minutes == '0),
        "digits disagree with zero count")
    `LSW_ASSERT_IMP(a_lap_needs_run, i_clk, i_rst_n, o_lap_wr_en, r_run,
        "lap written while stopped")
    `LSW_ASSERT_NEXT(a_hold_idle, i_clk, i_rst_n, !i_en,
        $stable(r_elapsed) && $stable(r_lap_cnt) && $stable(r_run),
        "state changed without an item")

endmodule

@@ design/lap_stopwatch.sv @@
// Lap stopwatch top level: input stage, lap RAM, state core, result register.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------
//   in      | i_in_valid / o_in_stall  | i_mode, i_lap_index
//   out     | o_out_valid / i_out_stall| o_time_*, o_watch_state, o_laps_stored,
//           |                          | o_lap_found, o_lap_minutes/seconds/centis
//
// One item per cycle sustained while the output does not stall; an accepted item
// goes into the input register, then its state update loads the result register,
// from which the result is taken.
// The lap RAM read is issued at acceptance; a lap written by the item ahead is
// forwarded. A stall on the output holds the result register and the input
// register, and then stalls the input. Synchronous reset; no clearing pass.
module lap_stopwatch #(
    parameter int MAX_LAPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_lap_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_time_minutes,
    output logic [5:0] o_time_seconds,
    output logic [6:0] o_time_centis,
    output logic [1:0] o_watch_state,
    output logic [7:0] o_laps_stored,
    output logic       o_lap_found,
    output logic [6:0] o_lap_minutes,
    output logic [5:0] o_lap_seconds,
    output logic [6:0] o_lap_centis
);
    import lsw_pkg::*;

    localparam int ADDR_W = (MAX_LAPS > 1) ? $clog2(MAX_LAPS) : 1;
    localparam int TIME_W = $bits(t_time);

    logic              advance;
    logic              in_accept;
    logic              core_en;
    logic              r_s1_valid;
    t_mode             r_s1_mode;
    logic [7:0]        r_s1_idx;
    logic              r_byp_hit;
    t_time             r_byp_data;
    logic              r_out_valid;
    t_result           r_out_result;
    t_result           core_result;
    logic              lap_wr_en;
    logic [ADDR_W-1:0] lap_wr_addr;
    t_time             lap_wr_data;
    logic [TIME_W-1:0] ram_rd_data;
    t_time             lap_data;

    // Handshake: the pipeline moves whenever the result register can load
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign core_en    = advance && r_s1_valid;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_mode <= t_mode'(i_mode);
            r_s1_idx  <= i_lap_index;
        end
    end

    // Forward a lap written at the same edge the read is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (in_accept) begin
            r_byp_hit <= lap_wr_en && (lap_wr_addr == i_lap_index[ADDR_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byp_data <= lap_wr_data;
        end
    end

    // Lap store
    lsw_ram #(
        .WIDTH  (TIME_W),
        .DEPTH  (MAX_LAPS),
        .ADDR_W (ADDR_W)
    ) u_lap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lap_wr_en),
        .i_wr_addr (lap_wr_addr),
        .i_wr_data (lap_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_lap_index[ADDR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign lap_data = r_byp_hit ? r_byp_data : t_time'(ram_rd_data);

    // State update and result formation
    lsw_core #(
        .MAX_LAPS (MAX_LAPS),
        .ADDR_W   (ADDR_W)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (core_en),
        .i_mode        (r_s1_mode),
        .i_lap_index   (r_s1_idx),
        .i_lap_data    (lap_data),
        .o_result      (core_result),
        .o_lap_wr_en   (lap_wr_en),
        .o_lap_wr_addr (lap_wr_addr),
        .o_lap_wr_data (lap_wr_data)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_en) begin
            r_out_result <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_time_minutes = r_out_result.elapsed.minutes;
    assign o_time_seconds = r_out_result.elapsed.seconds;
    assign o_time_centis  = r_out_result.elapsed.centis;
    assign o_watch_state  = r_out_result.watch_state;
    assign o_laps_stored  = r_out_result.laps_stored;
    assign o_lap_found    = r_out_result.lap_found;
    assign o_lap_minutes  = r_out_result.lap.minutes;
    assign o_lap_seconds  = r_out_result.lap.seconds;
    assign o_lap_centis   = r_out_result.lap.centis;

endmodule
